// File: hw/rtl/lcdst_pkg.sv
// ----------------------------------------------------------------------------
// lcdst_pkg: LCD scan timing and status package
// Item types, register addresses, timing constants and status bit positions.
// ----------------------------------------------------------------------------
package lcdst_pkg;

    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [8:0] SEARCH_END    = 9'd80;
    localparam logic [8:0] DRAW_END      = 9'd252;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;
    localparam logic [7:0] TOTAL_LINES   = 8'd154;

    localparam logic [15:0] ADDR_CTRL = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_LINE = 16'hFF44;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_DRAW   = 2'd3;

    localparam int STAT_COIN     = 2;
    localparam int STAT_EN_HBL   = 3;
    localparam int STAT_EN_VBL   = 4;
    localparam int STAT_EN_SRCH  = 5;
    localparam int STAT_EN_COIN  = 6;
    localparam int CTRL_ENABLE   = 7;

    localparam logic [7:0] STAT_KEEP_MASK = 8'h87;
    localparam logic [7:0] STAT_WR_MASK   = 8'h78;
    localparam logic [7:0] UNMAPPED_BYTE  = 8'hFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_request;
        logic       stat_request;
        logic [1:0] current_mode;
        logic [7:0] scan_line;
    } t_out_item;

endpackage

// File: hw/rtl/lcdst_in_reg.sv
// ----------------------------------------------------------------------------
// lcdst_in_reg: input item register
// Captures one item per cycle while not stalled and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lcdst_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lcdst_pkg::t_in_item i_in_item,
    input  logic                i_take,
    output logic                o_valid,
    output lcdst_pkg::t_in_item o_item
);

    logic                r_valid;
    lcdst_pkg::t_in_item r_item;
    logic                w_load;

    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_in_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: hw/rtl/lcdst_core.sv
// ----------------------------------------------------------------------------
// lcdst_core: scan timing state and step logic
// Holds dot, line, control, status and line-compare registers; computes the
// result of one item and commits the new state when the item advances.
// ----------------------------------------------------------------------------
module lcdst_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_write,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_fire,
    input  lcdst_pkg::t_in_item  i_item,
    output lcdst_pkg::t_out_item o_result
);

    logic [8:0] r_dot;
    logic [7:0] r_line;
    logic [7:0] r_ctrl;
    logic [7:0] r_stat;
    logic [7:0] r_cmp;

    logic [8:0] n_dot;
    logic [7:0] n_line;
    logic [7:0] n_ctrl;
    logic [7:0] n_stat;

    always_comb begin
        logic [8:0] d;
        logic [7:0] ln;
        logic [1:0] mode;
        logic       en;
        logic       coin;
        logic [7:0] rd;
        logic       vbl;
        logic       streq;

        n_dot  = r_dot;
        n_line = r_line;
        n_ctrl = r_ctrl;
        n_stat = r_stat;
        d      = r_dot + 9'd1;
        ln     = r_line;
        mode   = lcdst_pkg::MODE_HBLANK;
        en     = 1'b0;
        coin   = (r_line == r_cmp);
        rd     = 8'd0;
        vbl    = 1'b0;
        streq  = 1'b0;

        case (i_item.operation)
            lcdst_pkg::OP_TICK: begin
                if (!r_ctrl[lcdst_pkg::CTRL_ENABLE]) begin
                    n_dot  = 9'd0;
                    n_line = 8'd0;
                    n_stat = {r_stat[7:3], (r_cmp == 8'd0), lcdst_pkg::MODE_HBLANK};
                end else begin
                    if (d <= lcdst_pkg::SEARCH_END) begin
                        mode = lcdst_pkg::MODE_SEARCH;
                        en   = r_stat[lcdst_pkg::STAT_EN_SRCH];
                    end else if (d <= lcdst_pkg::DRAW_END) begin
                        mode = lcdst_pkg::MODE_DRAW;
                    end else begin
                        mode = lcdst_pkg::MODE_HBLANK;
                        en   = r_stat[lcdst_pkg::STAT_EN_HBL];
                    end
                    if (r_line >= lcdst_pkg::VISIBLE_LINES) begin
                        mode = lcdst_pkg::MODE_VBLANK;
                        en   = r_stat[lcdst_pkg::STAT_EN_VBL];
                    end
                    streq = (en && (mode != r_stat[1:0]))
                         || (coin && r_stat[lcdst_pkg::STAT_EN_COIN]);
                    if (d >= lcdst_pkg::DOTS_PER_LINE) begin
                        d   = 9'd0;
                        ln  = r_line + 8'd1;
                        vbl = (ln == lcdst_pkg::VISIBLE_LINES);
                    end
                    if (ln >= lcdst_pkg::TOTAL_LINES) begin
                        ln = 8'd0;
                    end
                    n_dot  = d;
                    n_line = ln;
                    n_stat = {r_stat[7:3], coin, mode};
                end
            end
            lcdst_pkg::OP_READ: begin
                if (i_item.address == lcdst_pkg::ADDR_CTRL) begin
                    rd = r_ctrl;
                end else if (i_item.address == lcdst_pkg::ADDR_STAT) begin
                    rd = r_stat;
                end else if (i_item.address == lcdst_pkg::ADDR_LINE) begin
                    rd = r_line;
                end else begin
                    rd = lcdst_pkg::UNMAPPED_BYTE;
                end
            end
            lcdst_pkg::OP_WRITE: begin
                if (i_item.address == lcdst_pkg::ADDR_CTRL) begin
                    n_ctrl = i_item.write_data;
                    if (!i_item.write_data[lcdst_pkg::CTRL_ENABLE]) begin
                        n_dot  = 9'd0;
                        n_line = 8'd0;
                        n_stat = {r_stat[7:2], lcdst_pkg::MODE_HBLANK};
                    end
                end else if (i_item.address == lcdst_pkg::ADDR_STAT) begin
                    n_stat = (r_stat & lcdst_pkg::STAT_KEEP_MASK)
                           | (i_item.write_data & lcdst_pkg::STAT_WR_MASK);
                end
            end
            default: begin
            end
        endcase

        o_result.read_data      = rd;
        o_result.vblank_request = vbl;
        o_result.stat_request   = streq;
        o_result.current_mode   = n_stat[1:0];
        o_result.scan_line      = n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= 9'd0;
            r_line <= 8'd0;
            r_ctrl <= 8'd0;
            r_stat <= 8'd0;
        end else if (i_fire) begin
            r_dot  <= n_dot;
            r_line <= n_line;
            r_ctrl <= n_ctrl;
            r_stat <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp <= 8'd0;
        end else if (i_cfg_write) begin
            r_cmp <= i_cfg_data;
        end
    end

endmodule

// File: hw/rtl/lcdst_out_reg.sv
// ----------------------------------------------------------------------------
// lcdst_out_reg: result register
// Holds one result until the consumer takes it; frees when not stalled.
// ----------------------------------------------------------------------------
module lcdst_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load_req,
    input  lcdst_pkg::t_out_item i_result,
    output logic                 o_load,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcdst_pkg::t_out_item o_out_item
);

    logic                 r_valid;
    lcdst_pkg::t_out_item r_item;

    assign o_load = i_load_req && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_item <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

endmodule

// File: hw/rtl/lcd_scan_timing_stat.sv
// ----------------------------------------------------------------------------
// lcd_scan_timing_stat: LCD scan timing and status block
// Dot/line scan counters, mode and coincidence status, interrupt requests
// and register reads/writes, one item per step.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_stall o_out_item (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (line compare)
//
// One item per cycle sustained while the output is not stalled.
// Input register, combinational step logic, result register.
// Synchronous active-low reset clears all counters and status bytes.
// A stall on the output holds the result and backs up into o_in_stall.
// ----------------------------------------------------------------------------
module lcd_scan_timing_stat (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  lcdst_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output lcdst_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data
);

    logic                 w_item_valid;
    lcdst_pkg::t_in_item  w_item;
    logic                 w_fire;
    lcdst_pkg::t_out_item w_result;

    assign o_cfg_ready = 1'b1;

    lcdst_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .i_take     (w_fire),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    lcdst_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_write (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_fire      (w_fire),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    lcdst_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load_req  (w_item_valid),
        .i_result    (w_result),
        .o_load      (w_fire),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: hw/rtl/lcdst_checker.sv
// ----------------------------------------------------------------------------
// lcdst_checker: port-level checks for the LCD scan timing block
// Watches the result channel for hold behavior and value consistency.
// ----------------------------------------------------------------------------
module lcdst_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input lcdst_pkg::t_out_item o_out_item
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_item_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("result changed while stalled");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.scan_line < lcdst_pkg::TOTAL_LINES)
        else $error("line count out of range");

    a_vblank_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.vblank_request
            |-> o_out_item.scan_line == lcdst_pkg::VISIBLE_LINES)
        else $error("vblank request off the first vblank line");

    a_req_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.vblank_request || o_out_item.stat_request)
            |-> o_out_item.read_data == 8'd0)
        else $error("request raised on a read item");

endmodule

bind lcd_scan_timing_stat lcdst_checker u_lcdst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
